// ===== hdl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Used by dq_ctrl, dq_datapath and double_ended_queue; depends on nothing.
package dq_pkg;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_PEEK       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
    } ctl_t;

endpackage

// ===== hdl/dq_ram.sv =====
// Generic simple RAM: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data between reads
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hdl/dq_ctrl.sv =====
// Sequencing state machine for the double-ended queue.
// Depends on dq_pkg for the state type and the command struct.
module dq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dq_pkg::ctl_t  ctl
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctl.capture = 1'b0;
        ctl.exec    = 1'b0;
        ctl.read    = 1'b0;
        cmd_stall   = 1'b1;
        rsp_valid   = 1'b0;
        unique case (state_reg)
            dq_pkg::S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = dq_pkg::S_EXEC;
                end
            end
            dq_pkg::S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = dq_pkg::S_READ;
            end
            dq_pkg::S_READ:
            begin
                ctl.read   = 1'b1;
                state_next = dq_pkg::S_RESP;
            end
            dq_pkg::S_RESP:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== hdl/dq_datapath.sv =====
// Datapath: command capture, front/back positions, count, status and entry RAM.
// Depends on dq_pkg and dq_ram.
module dq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dq_pkg::ctl_t                   ctl,
    input  logic [2:0]                     command,
    input  logic signed [dq_pkg::DATA_W-1:0] push_value,
    output logic signed [dq_pkg::DATA_W-1:0] front_value,
    output logic signed [dq_pkg::DATA_W-1:0] back_value,
    output logic [dq_pkg::COUNT_W-1:0]     entry_count,
    output logic [1:0]                     status
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [2:0]                cmd_reg;
    logic [dq_pkg::DATA_W-1:0] value_reg;
    logic [PTR_W-1:0]          front_reg;
    logic [PTR_W-1:0]          front_next;
    logic [PTR_W-1:0]          back_reg;
    logic [PTR_W-1:0]          back_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;

    logic                      we;
    logic [PTR_W-1:0]          waddr;
    logic [dq_pkg::DATA_W-1:0] rdata_a;
    logic [dq_pkg::DATA_W-1:0] rdata_b;
    logic                      is_full;
    logic                      is_empty;
    logic [PTR_W-1:0]          front_inc;
    logic [PTR_W-1:0]          front_dec;
    logic [PTR_W-1:0]          back_inc;
    logic [PTR_W-1:0]          back_dec;
    logic [CNT_W+dq_pkg::COUNT_W-1:0] count_ext;

    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - 1'b1;

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= command;
            value_reg <= push_value;
        end
    end

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = dq_pkg::ST_OK;
        we          = 1'b0;
        waddr       = back_reg;
        unique case (cmd_reg)
            dq_pkg::CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = back_reg;
                    back_next  = back_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    back_next  = back_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                // peek and unused codes leave positions and count unchanged
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            status_reg <= dq_pkg::ST_OK;
        end
        else if (ctl.exec)
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ctl.exec && we),
        .waddr   (waddr),
        .wdata   (value_reg),
        .re      (ctl.read),
        .raddr_a (front_reg),
        .raddr_b (back_dec),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign count_ext   = {{dq_pkg::COUNT_W{1'b0}}, count_reg};
    assign entry_count = count_ext[dq_pkg::COUNT_W-1:0];
    assign status      = status_reg;
    assign front_value = is_empty ? -32'sd1 : signed'(rdata_a);
    assign back_value  = is_empty ? -32'sd1 : signed'(rdata_b);

endmodule

// ===== hdl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
//
//   channel   handshake              payload
//   cmd       cmd_valid / cmd_stall  command, push_value
//   rsp       rsp_valid / rsp_stall  front_value, back_value, entry_count, status
//
// One word at a time: accept, execute (pointer update and RAM write), RAM read
// of front and back entries, then the response, in states S_IDLE, S_EXEC,
// S_READ and S_RESP, an order set by the write-then-read order on the entry RAM.
// cmd_stall stays high from acceptance until the response word leaves.
// A stalled response holds its fields. Reset clears positions, count and state;
// the entry RAM is not cleared and only written entries are ever shown.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         command,
    input  logic signed [31:0] push_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic [4:0]         entry_count,
    output logic [1:0]         status
);

    dq_pkg::ctl_t ctl;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    dq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (command),
        .push_value  (push_value),
        .front_value (front_value),
        .back_value  (back_value),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule
